// ===== rtl/bech32m_pkg.sv =====
// ----------------------------------------------------------------------------
// bech32m_pkg
// Shared types and constants of the bech32m checksum engine.
// ----------------------------------------------------------------------------
package bech32m_pkg;

   localparam int PREFIX_MAX   = 128;
   localparam int PREFIX_IDX_W = $clog2(PREFIX_MAX);
   localparam int PREFIX_CNT_W = $clog2(PREFIX_MAX + 1);

   localparam int CHECK_W = 30;
   localparam int SYM_W   = 5;
   localparam int CHAR_W  = 7;

   localparam logic [CHECK_W-1:0] CHECK_INIT     = 30'h0000_0001;
   localparam logic [CHECK_W-1:0] CONST_BECH32M  = 30'h2BC8_30A3;

   localparam logic [CHECK_W-1:0] GEN_POLY [5] = '{
      30'h3B6A_57B2, 30'h2650_8E6D, 30'h1EA1_19FA, 30'h3D42_33DD, 30'h2A14_62B3
   };

   // Charset letters in symbol order, as 7-bit ASCII.
   localparam logic [CHAR_W-1:0] CHARSET [32] = '{
      7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
      7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
      7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
      7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
   };

   typedef enum logic [1:0] {
      OP_PREFIX = 2'd0,
      OP_DATA   = 2'd1,
      OP_CREATE = 2'd2,
      OP_VERIFY = 2'd3
   } op_type;

endpackage

// ===== rtl/bech32m_fold.sv =====
// ----------------------------------------------------------------------------
// bech32m_fold
// One polymod step: shifts a 5-bit symbol into the check register and
// reduces by the BCH generator.
// ----------------------------------------------------------------------------
module bech32m_fold
   import bech32m_pkg::*;
(
   input  logic [CHECK_W-1:0] check_value,
   input  logic [SYM_W-1:0]   symbol,
   output logic [CHECK_W-1:0] folded
);

   logic [SYM_W-1:0] top;

   always_comb begin
      top    = check_value[CHECK_W-1 -: SYM_W];
      folded = {check_value[CHECK_W-SYM_W-1:0], symbol};
      for (int i = 0; i < SYM_W; i++) begin
         if (top[i]) begin
            folded = folded ^ GEN_POLY[i];
         end
      end
   end

endmodule

// ===== rtl/bech32m_prefix_buf.sv =====
// ----------------------------------------------------------------------------
// bech32m_prefix_buf
// Buffer of the low 5 bits of the prefix characters, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module bech32m_prefix_buf
   import bech32m_pkg::*;
(
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [PREFIX_IDX_W-1:0] wr_addr,
   input  logic [SYM_W-1:0]        wr_data,
   input  logic [PREFIX_IDX_W-1:0] rd_addr,
   output logic [SYM_W-1:0]        rd_data
);

   logic [SYM_W-1:0] prefix_mem_ff [PREFIX_MAX];
   logic [SYM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prefix_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= prefix_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bech32m_checksum_engine.sv =====
// ----------------------------------------------------------------------------
// bech32m_checksum_engine
// Streaming bech32 / bech32m checksum creation and verification.
// ----------------------------------------------------------------------------
// A prefix character is folded in as it is accepted, and so is a data symbol once
// the run is in its data phase. The first data symbol or finish of a run first
// flushes the zero separator and the N buffered prefix symbols through the single
// polymod step unit, fed by the prefix buffer's one read port; a data symbol that
// ends such a flush is then folded in a state of its own. After its accept, a
// create-finish in the data phase folds six zero symbols and then emits its six
// result items. A verify-finish emits its one result item. Output back pressure
// stretches the emit cycles. The input is ready only while the sequencer is idle;
// a result item may still wait at the output then.
module bech32m_checksum_engine
   import bech32m_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [6:0] value
   input  logic [1:0]         req_tuser,   // [1:0] op
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,   // [4:0] symbol, [11:5] letter
   output logic [1:0]         rsp_tuser,   // [0] check_ok, [1] error
   output logic               rsp_tlast,
   input  logic               csr_wen,
   input  logic [CHECK_W-1:0] csr_wdata
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SEP    = 7'b0000010,
      ST_FLUSH  = 7'b0000100,
      ST_SYMBOL = 7'b0001000,
      ST_ZERO   = 7'b0010000,
      ST_EMIT   = 7'b0100000,
      ST_VERIFY = 7'b1000000
   } state_type;

   state_type                state_ff, state_in, after_flush;
   logic [CHECK_W-1:0]       check_ff, check_in;
   logic [CHECK_W-1:0]       const_ff;
   logic [PREFIX_CNT_W-1:0]  count_ff, count_in;
   logic [PREFIX_IDX_W-1:0]  idx_ff, idx_in;
   logic [2:0]               step_ff, step_in;
   logic                     in_data_ff, in_data_in;
   logic                     err_ff, err_in;
   op_type                   op_ff, op_in;
   logic [CHAR_W-1:0]        val_ff, val_in;
   logic [CHECK_W-1:0]       emit_ff, emit_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]         rsp_sym_ff, rsp_sym_in;
   logic [CHAR_W-1:0]        rsp_letter_ff, rsp_letter_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic                     rsp_err_ff, rsp_err_in;
   logic                     rsp_last_ff, rsp_last_in;

   op_type                   req_op;
   logic [CHAR_W-1:0]        req_val;
   logic [SYM_W-1:0]         fold_sym;
   logic [CHECK_W-1:0]       fold_out;
   logic                     mem_wen;
   logic [PREFIX_IDX_W-1:0]  mem_raddr;
   logic [SYM_W-1:0]         mem_rdata;
   logic                     out_free;
   logic                     flush_done;

   assign req_op     = op_type'(req_tuser);
   assign req_val    = req_tdata[CHAR_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign mem_raddr  = (state_ff == ST_SEP) ? '0 : idx_ff + PREFIX_IDX_W'(1);
   assign flush_done = ({1'b0, idx_ff} + PREFIX_CNT_W'(1)) == count_ff;

   bech32m_fold u_fold (
      .check_value (check_ff),
      .symbol      (fold_sym),
      .folded      (fold_out)
   );

   bech32m_prefix_buf u_prefix_buf (
      .clock   (clock),
      .wr_en   (mem_wen),
      .wr_addr (count_ff[PREFIX_IDX_W-1:0]),
      .wr_data (req_val[SYM_W-1:0]),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      unique case (op_ff)
         OP_DATA:   after_flush = ST_SYMBOL;
         OP_CREATE: after_flush = ST_ZERO;
         default:   after_flush = ST_VERIFY;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      check_in      = check_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      in_data_in    = in_data_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sym_in    = rsp_sym_ff;
      rsp_letter_in = rsp_letter_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_last_in   = rsp_last_ff;
      fold_sym      = '0;
      mem_wen       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_op;
               val_in = req_val;
               if (req_op == OP_PREFIX) begin
                  if (in_data_ff || (count_ff >= PREFIX_CNT_W'(PREFIX_MAX))) begin
                     err_in = 1'b1;
                  end else begin
                     fold_sym = {3'b000, req_val[CHAR_W-1:SYM_W]};
                     check_in = fold_out;
                     mem_wen  = 1'b1;
                     count_in = count_ff + PREFIX_CNT_W'(1);
                  end
               end else if (!in_data_ff) begin
                  state_in = ST_SEP;
               end else if (req_op == OP_DATA) begin
                  fold_sym = req_val[SYM_W-1:0];
                  check_in = fold_out;
               end else if (req_op == OP_CREATE) begin
                  step_in  = '0;
                  state_in = ST_ZERO;
               end else begin
                  state_in = ST_VERIFY;
               end
            end
         end
         ST_SEP: begin
            // The separator folds as a zero symbol; the buffer read of entry 0
            // is issued in the same cycle.
            check_in = fold_out;
            idx_in   = '0;
            step_in  = '0;
            if (count_ff == '0) begin
               in_data_in = 1'b1;
               state_in   = after_flush;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            fold_sym = mem_rdata;
            check_in = fold_out;
            idx_in   = idx_ff + PREFIX_IDX_W'(1);
            if (flush_done) begin
               in_data_in = 1'b1;
               state_in   = after_flush;
            end
         end
         ST_SYMBOL: begin
            fold_sym = val_ff[SYM_W-1:0];
            check_in = fold_out;
            state_in = ST_IDLE;
         end
         ST_ZERO: begin
            check_in = fold_out;
            step_in  = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               emit_in  = fold_out ^ const_ff;
               step_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = emit_ff[CHECK_W-1 -: SYM_W];
               rsp_letter_in = CHARSET[emit_ff[CHECK_W-1 -: SYM_W]];
               rsp_ok_in     = 1'b0;
               rsp_err_in    = err_ff;
               rsp_last_in   = (step_ff == 3'd5);
               emit_in       = {emit_ff[CHECK_W-SYM_W-1:0], {SYM_W{1'b0}}};
               step_in       = step_ff + 3'd1;
               if (step_ff == 3'd5) begin
                  check_in   = CHECK_INIT;
                  count_in   = '0;
                  in_data_in = 1'b0;
                  err_in     = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_VERIFY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = '0;
               rsp_letter_in = '0;
               rsp_ok_in     = (check_ff == const_ff);
               rsp_err_in    = err_ff;
               rsp_last_in   = 1'b1;
               check_in      = CHECK_INIT;
               count_in      = '0;
               in_data_in    = 1'b0;
               err_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         check_ff     <= CHECK_INIT;
         const_ff     <= CONST_BECH32M;
         count_ff     <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         in_data_ff   <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         check_ff     <= check_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         in_data_ff   <= in_data_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            const_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      emit_ff       <= emit_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_letter_ff, rsp_sym_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_ok_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A flush only runs when there is at least one buffered prefix symbol.
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> count_ff != '0)
      else $error("prefix flush with an empty buffer");

   // The separator is folded only once per run.
   a_sep_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEP |-> !in_data_ff)
      else $error("separator folded in the data phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PREFIX_CNT_W'(PREFIX_MAX))
      else $error("prefix count beyond the buffer depth");

   // After the sixth checksum item the run state is back at its start values.
   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && out_free && (step_ff == 3'd5)
      |=> (check_ff == CHECK_INIT) && (count_ff == '0) && !in_data_ff && !err_ff)
      else $error("run state not cleared after create");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the bech32m checksum engine.
// ----------------------------------------------------------------------------
// Prefix characters, data symbols and finishes are streamed into the engine
// while the sender idles in random bursts and the receiver stalls on its own
// pattern. A behavioral predictor keeps its own check register and prefix
// buffer. It works out the checksum symbols and verify results of every
// finish, and a checker compares each result item with the oldest pending one.
// Directed runs cover field extremes, late prefix characters, a full prefix
// buffer, a long output stall and several final constants. Random runs create
// a checksum and verify the same message again, mixed with unstructured items.
// ----------------------------------------------------------------------------
module tb_top;
   import bech32m_pkg::*;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 160;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RANDOM_ITEMS     = 80;

   localparam logic [CHECK_W-1:0] BECH32M_CONST = 30'h2BC8_30A3;
   localparam logic [CHECK_W-1:0] BECH32_CONST  = 30'h0000_0001;
   localparam logic [CHECK_W-1:0] ALL_ONES      = 30'h3FFF_FFFF;
   localparam logic [8*32-1:0] CHARSET_LETTERS = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   typedef struct packed {
      logic [4:0] symbol;
      logic [6:0] letter;
      logic       check_ok;
      logic       error;
      logic       last;
   } checksum_result_type;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_MOSTLY
   } ready_pattern_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;   // [6:0] value
   logic [1:0]         req_tuser  = '0;   // [1:0] op
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [15:0]        rsp_tdata;         // [4:0] symbol, [11:5] letter
   logic [1:0]         rsp_tuser;         // [0] check_ok, [1] error
   logic               rsp_tlast;
   logic               csr_wen    = 1'b0;
   logic [CHECK_W-1:0] csr_wdata  = '0;

   bech32m_checksum_engine DUT (.*);

   always #1 clock = ~clock;

   // Predicted engine state.
   logic [CHECK_W-1:0]  final_const;
   logic [CHECK_W-1:0]  check_reg;
   logic [4:0]          prefix_lows [PREFIX_MAX];
   int                  prefix_len;
   logic                in_data;
   logic                run_error;
   logic [4:0]          created_symbols [6];
   checksum_result_type pending_results [$];

   int items_sent    = 0;
   int burst_left    = 0;
   int mismatches    = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int stall_count   = 0;
   int idle_cycles   = 0;
   ready_pattern_type   stall_mode = READY_ALWAYS;
   checksum_result_type rsp_seen;
   checksum_result_type rsp_wanted;

   function automatic logic [CHECK_W-1:0] polymod_step(input logic [CHECK_W-1:0] c,
                                                       input logic [4:0] sym);
      logic [4:0]         top;
      logic [CHECK_W-1:0] r;
      top = c[29:25];
      r = {c[24:0], sym};
      if (top[0]) r ^= 30'h3B6A_57B2;
      if (top[1]) r ^= 30'h2650_8E6D;
      if (top[2]) r ^= 30'h1EA1_19FA;
      if (top[3]) r ^= 30'h3D42_33DD;
      if (top[4]) r ^= 30'h2A14_62B3;
      return r;
   endfunction

   function automatic void clear_run();
      check_reg = BECH32_CONST;
      prefix_len = 0;
      in_data = 1'b0;
      run_error = 1'b0;
   endfunction

   function automatic void predict_checksum_item(input op_type op, input logic [6:0] value);
      checksum_result_type entry;
      logic [CHECK_W-1:0]  residue;
      int                  i;
      // The first data symbol or finish folds the separator, then the buffered low parts.
      if (op != OP_PREFIX && !in_data) begin
         check_reg = polymod_step(check_reg, 5'd0);
         for (i = 0; i < prefix_len; i++) check_reg = polymod_step(check_reg, prefix_lows[i]);
         in_data = 1'b1;
      end
      case (op)
         OP_PREFIX: begin
            if (in_data || prefix_len >= PREFIX_MAX) begin
               run_error = 1'b1;
            end else begin
               check_reg = polymod_step(check_reg, {3'b000, value[6:5]});
               prefix_lows[prefix_len] = value[4:0];
               prefix_len++;
            end
         end
         OP_DATA: check_reg = polymod_step(check_reg, value[4:0]);
         OP_CREATE: begin
            for (i = 0; i < 6; i++) check_reg = polymod_step(check_reg, 5'd0);
            residue = check_reg ^ final_const;
            for (i = 0; i < 6; i++) begin
               entry.symbol = residue[5*(5-i) +: 5];
               entry.letter = CHARSET_LETTERS[8*(31-int'(entry.symbol)) +: 7];
               entry.check_ok = 1'b0;
               entry.error = run_error;
               entry.last = (i == 5);
               created_symbols[i] = entry.symbol;
               pending_results.insert(pending_results.size(), entry);
            end
            clear_run();
         end
         default: begin
            entry.symbol = '0;
            entry.letter = '0;
            entry.check_ok = (check_reg == final_const);
            entry.error = run_error;
            entry.last = 1'b1;
            pending_results.insert(pending_results.size(), entry);
            clear_run();
         end
      endcase
   endfunction

   // Offers one item and waits for its handshake. The valid stays high so that
   // the next item of a burst follows without a gap.
   task automatic send_item(input op_type op, input logic [6:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 50);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, value};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predict_checksum_item(op, value);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // Items without results may still keep the engine busy flushing.
      repeat (DRAIN_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_final_constant(input logic [CHECK_W-1:0] v);
      wait_for_drain();
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      final_const = v;
   endtask

   // Creates a checksum for a random message, then sends the message again with
   // the checksum appended and verifies it.
   task automatic send_round_trip(input int n_prefix, input int n_data);
      logic [6:0] chars [$];
      logic [6:0] syms [$];
      logic [4:0] checksum [6];
      int         i;
      int         flip;
      for (i = 0; i < n_prefix; i++) chars.insert(chars.size(), 7'($urandom_range(33, 126)));
      for (i = 0; i < n_data; i++) syms.insert(syms.size(), 7'($urandom));
      for (i = 0; i < n_prefix; i++) send_item(OP_PREFIX, chars[i]);
      for (i = 0; i < n_data; i++) send_item(OP_DATA, syms[i]);
      send_item(OP_CREATE, 7'($urandom));
      checksum = created_symbols;
      // A damaged symbol now and then must make the verify fail.
      if ($urandom_range(0, 3) == 0) begin
         flip = $urandom_range(0, 5);
         checksum[flip] ^= 5'($urandom_range(1, 31));
      end
      for (i = 0; i < n_prefix; i++) send_item(OP_PREFIX, chars[i]);
      for (i = 0; i < n_data; i++) send_item(OP_DATA, syms[i]);
      for (i = 0; i < 6; i++) send_item(OP_DATA, {2'($urandom), checksum[i]});
      send_item(OP_VERIFY, 7'($urandom));
   endtask

   task automatic send_noise(input int n);
      int i;
      for (i = 0; i < n; i++) send_item(op_type'(2'($urandom)), 7'($urandom));
      send_item(($urandom_range(0, 1) == 0) ? OP_CREATE : OP_VERIFY, 7'($urandom));
   endtask

   task automatic test_field_extremes();
      send_item(OP_PREFIX, 7'd33);
      send_item(OP_PREFIX, 7'd126);
      send_item(OP_PREFIX, 7'd0);
      send_item(OP_PREFIX, 7'd127);
      send_item(OP_DATA, 7'd0);
      send_item(OP_DATA, 7'd31);
      send_item(OP_DATA, 7'd127);
      send_item(OP_DATA, 7'd96);
      send_item(OP_CREATE, 7'd127);
      // A finish right after another one checks the empty run.
      send_item(OP_VERIFY, 7'd0);
      send_item(OP_CREATE, 7'd85);
      // A finish without data still folds the separator and the prefix.
      send_item(OP_PREFIX, 7'h61);
      send_item(OP_CREATE, 7'd0);
      send_item(OP_PREFIX, 7'h61);
      send_item(OP_VERIFY, 7'd42);
      send_round_trip(1, 0);
   endtask

   task automatic test_prefix_after_data();
      send_item(OP_PREFIX, 7'h62);
      send_item(OP_DATA, 7'd5);
      send_item(OP_PREFIX, 7'h63);
      send_item(OP_DATA, 7'd7);
      send_item(OP_VERIFY, 7'd0);
      // The error flag must not outlive its run.
      send_item(OP_PREFIX, 7'h78);
      send_item(OP_CREATE, 7'd0);
   endtask

   task automatic test_prefix_overflow();
      int i;
      for (i = 0; i < PREFIX_MAX + 2; i++) send_item(OP_PREFIX, 7'($urandom));
      send_item(OP_DATA, 7'($urandom));
      send_item(OP_CREATE, 7'($urandom));
      // A buffer filled exactly to the limit is still a clean run.
      for (i = 0; i < PREFIX_MAX; i++) send_item(OP_PREFIX, 7'($urandom_range(33, 126)));
      send_item(OP_VERIFY, 7'($urandom));
   endtask

   task automatic test_output_stall();
      int i;
      wait_for_drain();
      hold_requests++;
      for (i = 0; i < 4; i++) begin
         send_item(OP_PREFIX, 7'($urandom));
         send_item(OP_DATA, 7'($urandom));
         send_item(OP_CREATE, 7'($urandom));
      end
      wait_for_drain();
   endtask

   task automatic test_final_constants();
      logic [CHECK_W-1:0] setting;
      int                 k;
      for (k = 0; k < 5; k++) begin
         case (k)
            0: setting = BECH32_CONST;
            1: setting = '0;
            2: setting = ALL_ONES;
            3: setting = 30'($urandom);
            default: setting = BECH32M_CONST;
         endcase
         write_final_constant(setting);
         send_round_trip($urandom_range(1, 4), $urandom_range(0, 6));
      end
   endtask

   task automatic test_random(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7) begin
            send_round_trip(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 6),
                            $urandom_range(0, 12));
         end else begin
            send_noise($urandom_range(0, 12));
         end
      end
   endtask

   initial begin
      final_const = BECH32M_CONST;
      clear_run();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_prefix_after_data();
      test_prefix_overflow();
      test_output_stall();
      test_final_constants();
      test_random(RANDOM_ITEMS / 2);
      write_final_constant(30'($urandom));
      test_random(RANDOM_ITEMS / 2);
      wait_for_drain();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Receiver: a long hold-off on request, otherwise a pattern that changes now and then.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_count++;
         if (stall_count % 97 == 0) stall_mode = ready_pattern_type'($urandom_range(0, 3));
         case (stall_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= (stall_count % 5 == 0);
            default:      rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen.symbol   = rsp_tdata[4:0];
         rsp_seen.letter   = rsp_tdata[11:5];
         rsp_seen.check_ok = rsp_tuser[0];
         rsp_seen.error    = rsp_tuser[1];
         rsp_seen.last     = rsp_tlast;
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display({"Unexpected result item: symbol=%0d letter=%h ",
                         "check_ok=%b error=%b last=%b"},
                        rsp_seen.symbol, rsp_seen.letter, rsp_seen.check_ok, rsp_seen.error,
                        rsp_seen.last);
            mismatches++;
         end else begin
            rsp_wanted = pending_results.pop_front();
            if (rsp_seen !== rsp_wanted) begin
               if (mismatches < 10)
                  $display({"Result mismatch: expected symbol=%0d letter=%h check_ok=%b ",
                            "error=%b last=%b, got symbol=%0d letter=%h check_ok=%b ",
                            "error=%b last=%b"},
                           rsp_wanted.symbol, rsp_wanted.letter, rsp_wanted.check_ok,
                           rsp_wanted.error, rsp_wanted.last, rsp_seen.symbol,
                           rsp_seen.letter, rsp_seen.check_ok, rsp_seen.error, rsp_seen.last);
               mismatches++;
            end
         end
      end
   end

   // Ends a hung run: too many cycles in a row without a handshake on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule

// ===== bech32m_checksum_engine.f =====
rtl/bech32m_pkg.sv
rtl/bech32m_fold.sv
rtl/bech32m_prefix_buf.sv
rtl/bech32m_checksum_engine.sv
test/tb_top.sv
